// File: hw/rtl/clns_pkg.sv
// Shared types, constants and lookup functions for the character LCD nibble sequencer.
package clns_pkg;

    // Duration field width and configuration register index width
    localparam int DUR_W = 24;
    localparam int CFG_IDX_W = 3;

    typedef logic [DUR_W-1:0] dur_t;

    // Request kinds
    typedef enum logic [1:0] {
        FUNC_INIT = 2'd0,
        FUNC_DATA = 2'd1,
        FUNC_CMD  = 2'd2,
        FUNC_POS  = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_WAIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LONG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SHORT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT = 3'd5;

    // Reset values of the timing registers
    localparam dur_t RST_SETUP      = 24'd8;
    localparam dur_t RST_HOLD       = 24'd1;
    localparam dur_t RST_CMD_WAIT   = 24'd3700;
    localparam dur_t RST_INIT_LONG  = 24'd410000;
    localparam dur_t RST_INIT_SHORT = 24'd10000;
    localparam dur_t RST_CLEAR_WAIT = 24'd153000;

    // Set-position command flag
    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;

    // Init sequence: 14 nibbles, the clear byte's low nibble is nibble 9
    localparam logic [3:0] INIT_LAST_NIB  = 4'd13;
    localparam logic [3:0] INIT_CLEAR_NIB = 4'd9;
    localparam logic [3:0] INIT_LONG_NIB  = 4'd0;
    localparam logic [3:0] INIT_SHORT_NIB = 4'd1;
    localparam logic [3:0] BYTE_LAST_NIB  = 4'd1;

    // Timing registers as a group
    typedef struct packed {
        dur_t setup;
        dur_t hold;
        dur_t cmd_wait;
        dur_t init_long;
        dur_t init_short;
        dur_t clear_wait;
    } cfg_t;

    // One classified request as it travels to the back end
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] data;
    } req_t;

    // DDRAM base address of each display line
    function automatic logic [7:0] line_base(input logic [1:0] ln);
        logic [7:0] b;
        unique case (ln)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    // Bytes that follow the 3,3,3,2 wake-up nibbles
    function automatic logic [7:0] init_byte(input logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0:    b = 8'h2C;   // function set: 4-bit, 2 lines, 5x10
            3'd1:    b = 8'h08;   // display off
            3'd2:    b = 8'h01;   // clear
            3'd3:    b = 8'h06;   // entry mode
            3'd4:    b = 8'h0C;   // display on
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Nibble at position idx of the init sequence
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] k;
        logic [7:0] b;
        logic [3:0] n;
        k = idx - 4'd4;
        b = init_byte(k[3:1]);
        if (idx < 4'd3) begin
            n = 4'h3;
        end else if (idx == 4'd3) begin
            n = 4'h2;
        end else begin
            n = k[0] ? b[3:0] : b[7:4];
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/clns_front.sv
// Front end: classifies a request and forms the byte it sends.
module clns_front
    import clns_pkg::*;
(
    input  logic [1:0] func,
    input  logic [7:0] byte_value,
    input  logic [1:0] line,
    input  logic [5:0] offset,
    output req_t       req
);

    logic [7:0] addr;

    // Position address wraps within 8 bits
    assign addr = line_base(line) + {2'b00, offset};

    always_comb begin
        req = '0;
        unique case (func_t'(func))
            FUNC_INIT: begin
                req.is_init = 1'b1;
            end
            FUNC_DATA: begin
                req.rs   = 1'b1;
                req.data = byte_value;
            end
            FUNC_CMD: begin
                req.data = byte_value;
            end
            FUNC_POS: begin
                req.data = SET_DDRAM_ADDR | addr;
            end
            default: begin
                req = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/clns_queue.sv
// Two-entry request queue between front and back ends.
module clns_queue
    import clns_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  req_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output req_t head
);

    req_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/clns_back.sv
// Back end: walks a request's nibbles and emits one pin phase per cycle while m_ready allows.
module clns_back
    import clns_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_not_empty,
    input  req_t       q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_reg_select,
    output logic       m_enable,
    output logic [3:0] m_nibble,
    output dur_t       m_duration,
    output logic       m_last
);

    logic       busy_reg, busy_next;
    req_t       desc_reg, desc_next;
    logic [3:0] nib_reg, nib_next;
    logic       phase_reg, phase_next;
    logic       valid_reg, valid_next;
    logic       rs_reg, en_reg, last_reg;
    logic [3:0] nibble_reg;
    dur_t       dur_reg;

    req_t        cur;
    logic        have, adv, emit, is_last, waits;
    logic [3:0]  nib_val;
    dur_t        extra, wait_val, dur_val;
    logic [DUR_W+1:0] low_sum;

    assign cur   = busy_reg ? desc_reg : q_head;
    assign have  = busy_reg || q_not_empty;
    assign adv   = !valid_reg || m_ready;
    assign emit  = adv && have;
    assign q_pop = emit && !busy_reg;

    // Phase contents for the current nibble position
    always_comb begin
        is_last = phase_reg &&
                  (cur.is_init ? (nib_reg == INIT_LAST_NIB) : (nib_reg == BYTE_LAST_NIB));
        nib_val = cur.is_init ? init_nibble(nib_reg)
                              : (nib_reg[0] ? cur.data[3:0] : cur.data[7:4]);
        // wake-up nibbles and every low nibble carry the command wait
        waits   = cur.is_init ? ((nib_reg < 4'd4) || nib_reg[0]) : nib_reg[0];
        extra   = '0;
        if (cur.is_init) begin
            priority if (nib_reg == INIT_LONG_NIB) begin
                extra = cfg.init_long;
            end else if (nib_reg == INIT_SHORT_NIB) begin
                extra = cfg.init_short;
            end else if (nib_reg == INIT_CLEAR_NIB) begin
                extra = cfg.clear_wait;
            end else begin
                extra = '0;
            end
        end
        wait_val = waits ? cfg.cmd_wait : '0;
        low_sum  = {2'b00, cfg.hold} + {2'b00, wait_val} + {2'b00, extra};
        if (!phase_reg) begin
            dur_val = cfg.setup;
        end else if (low_sum[DUR_W+1:DUR_W] != 2'b00) begin
            dur_val = '1;
        end else begin
            dur_val = low_sum[DUR_W-1:0];
        end
    end

    // Sequencer next state
    always_comb begin
        busy_next  = busy_reg;
        desc_next  = desc_reg;
        nib_next   = nib_reg;
        phase_next = phase_reg;
        valid_next = valid_reg && !m_ready;
        if (emit) begin
            valid_next = 1'b1;
            if (!busy_reg) begin
                desc_next = q_head;
            end
            if (is_last) begin
                busy_next  = 1'b0;
                nib_next   = '0;
                phase_next = 1'b0;
            end else begin
                busy_next  = 1'b1;
                phase_next = !phase_reg;
                nib_next   = phase_reg ? nib_reg + 4'd1 : nib_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            nib_reg   <= '0;
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            nib_reg   <= nib_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // Descriptor and output payload
    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
        if (emit) begin
            rs_reg     <= cur.rs;
            en_reg     <= !phase_reg;
            nibble_reg <= nib_val;
            dur_reg    <= dur_val;
            last_reg   <= is_last;
        end
    end

    assign m_valid      = valid_reg;
    assign m_reg_select = rs_reg;
    assign m_enable     = en_reg;
    assign m_nibble     = nibble_reg;
    assign m_duration   = dur_reg;
    assign m_last       = last_reg;

endmodule

// File: hw/rtl/char_lcd_nibble_sequencer_core.sv
// Top level of the 4-bit character LCD bus sequencer.
//
// Requests (init, data byte, command byte, set position) enter on the s_
// valid/ready channel. Each request becomes a list of pin phases on the m_
// channel: per nibble one enable-high phase (setup time) and one enable-low
// phase (hold plus waits, saturated to 24 bits); m_last marks the final one.
// A byte request gives 4 phases, init gives 28.
// An accepted item is first written into the request queue; the sequencer then
// moves its first phase from the queue into the output register.
// Throughput: one phase per cycle while m_ready allows, set by the back-end
// sequencer that walks one nibble phase per cycle.
// A two-entry queue decouples the front end, so up to two further items are
// taken while the back end works or waits.
// When the receiver holds m_ready low, the phase holds in the output register
// and the sequencer pauses; the queue fills and then s_ready drops.
// Timing registers are written through cfg_wr_en/cfg_index/cfg_wdata; the user must
// write them only while the block is idle (not enforced). Indexes above 5 are ignored.
// Reset (aresetn low, synchronous) empties the queue and the output register
// and restores the timing registers to their defaults.
module char_lcd_nibble_sequencer_core
    import clns_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic [7:0]           s_byte_value,
    input  logic [1:0]           s_line,
    input  logic [5:0]           s_offset,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_reg_select,
    output logic                 m_enable,
    output logic [3:0]           m_nibble,
    output logic [DUR_W-1:0]     m_duration,
    output logic                 m_last
);

    cfg_t cfg_reg, cfg_next;
    req_t front_req, q_head;
    logic q_full, q_not_empty, q_pop;

    // Timing register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SETUP:      cfg_next.setup      = cfg_wdata;
                CFG_HOLD:       cfg_next.hold       = cfg_wdata;
                CFG_CMD_WAIT:   cfg_next.cmd_wait   = cfg_wdata;
                CFG_INIT_LONG:  cfg_next.init_long  = cfg_wdata;
                CFG_INIT_SHORT: cfg_next.init_short = cfg_wdata;
                CFG_CLEAR_WAIT: cfg_next.clear_wait = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setup      <= RST_SETUP;
            cfg_reg.hold       <= RST_HOLD;
            cfg_reg.cmd_wait   <= RST_CMD_WAIT;
            cfg_reg.init_long  <= RST_INIT_LONG;
            cfg_reg.init_short <= RST_INIT_SHORT;
            cfg_reg.clear_wait <= RST_CLEAR_WAIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !q_full;

    clns_front u_front (
        .func       (s_func),
        .byte_value (s_byte_value),
        .line       (s_line),
        .offset     (s_offset),
        .req        (front_req)
    );

    clns_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (front_req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    clns_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_select (m_reg_select),
        .m_enable     (m_enable),
        .m_nibble     (m_nibble),
        .m_duration   (m_duration),
        .m_last       (m_last)
    );

    // A request always ends on an enable-low phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_enable && m_last))
        else $error("last phase with enable high");

    // The enable-low half of a nibble follows its enable-high half at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_enable) |=> m_valid)
        else $error("enable-low phase not ready after enable-high phase");

    // Enable alternates between consecutive phases
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (!m_valid || (m_enable != $past(m_enable))))
        else $error("enable level did not alternate");

endmodule
